[rtl/sset_pkg.sv]
// Shared types and constants for the sorted set search, insert and delete core.
package sset_pkg;

   // Stored keys are biased by KEY_BIAS so that every legal key is non-negative.
   localparam int unsigned KEY_W = 21;
   localparam logic signed [31:0] KEY_LOW  = -32'sd100;
   localparam logic signed [31:0] KEY_HIGH = 32'sd1000000;
   localparam logic [KEY_W-1:0] KEY_BIAS = 21'd100;

   localparam int unsigned RANK_W  = 6;
   localparam int unsigned COUNT_W = 7;

   // Request codes
   localparam logic [1:0] REQ_SEARCH = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [RANK_W-1:0]  rank;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic cmp;
      logic ins;
      logic del;
   } ctl_type;

endpackage

[rtl/sset_cell.sv]
// One storage cell of the sorted key chain: holds a key, compares it, shifts left or right.
module sset_cell (
   input  logic                       clock,
   input  sset_pkg::ctl_type          ctl,
   input  logic                       occupied,
   input  logic [sset_pkg::KEY_W-1:0] new_key,
   input  logic [sset_pkg::KEY_W-1:0] left_key,
   input  logic [sset_pkg::KEY_W-1:0] right_key,
   input  logic                       left_lt,
   output logic [sset_pkg::KEY_W-1:0] key,
   output logic                       lt,
   output logic                       eq
);

   logic [sset_pkg::KEY_W-1:0] key_ff, key_in;
   logic                       lt_ff, lt_in;
   logic                       eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctl.cmp) begin
         lt_in = occupied && (key_ff < new_key);
         eq_in = occupied && (key_ff == new_key);
      end
      // Cells below the insertion point keep their key; on insert the boundary cell takes
      // the new key and the rest their lower neighbor; on delete those cells take the upper one.
      priority if (ctl.ins && !lt_ff) begin
         key_in = left_lt ? new_key : left_key;
      end else if (ctl.del && !lt_ff) begin
         key_in = right_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

[rtl/sorted_set_search_insert_delete_core.sv]
// Sorted set core: a chain of compare-and-shift cells holding keys in ascending order.
// Every cell compares on the accept edge; the chain shifts one place on the commit edge,
// which also loads the registered result beat. The commit waits while a stalled result
// beat is held. A new request is accepted only after the previous one has committed.
// Reset (synchronous, active high) empties the set at once; cell keys are not cleared.
module sorted_set_search_insert_delete_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sset_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sset_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic S_IDLE   = 1'b0;
   localparam logic S_UPDATE = 1'b1;

   logic                       state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [1:0]                 op_ff;
   logic                       range_ok_ff;
   logic [sset_pkg::KEY_W-1:0] val_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   sset_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       accept, commit, range_ok, found, full;
   logic                       do_ins, do_del;
   logic [sset_pkg::KEY_W-1:0] val_now, cell_new;
   logic [1:0]                 status;
   logic [sset_pkg::RANK_W-1:0] rank;
   sset_pkg::ctl_type          ctl;

   logic [sset_pkg::KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]        cell_lt;
   logic [CAPACITY-1:0]        cell_eq;
   logic [CAPACITY-1:0]        cell_occ;
   logic [CAPACITY-1:0]        boundary;

   assign accept  = req_valid && !req_stall;
   assign commit  = (state_ff == S_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff == S_UPDATE);

   assign range_ok = ($signed(req_data.key) > sset_pkg::KEY_LOW) &&
                     ($signed(req_data.key) < sset_pkg::KEY_HIGH);
   assign val_now  = req_data.key[sset_pkg::KEY_W-1:0] + sset_pkg::KEY_BIAS;
   assign cell_new = accept ? val_now : val_ff;

   assign ctl.cmp = accept;
   assign ctl.ins = commit && do_ins;
   assign ctl.del = commit && do_del;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = CW'(i) < count_ff;
      if (i == 0) begin : g_head
         assign boundary[i] = !cell_lt[i];
         sset_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (cell_new),
            .left_key  (cell_new),
            .right_key ((CAPACITY > 1) ? cell_key[(CAPACITY > 1) ? 1 : 0] : cell_key[0]),
            .left_lt   (1'b1),
            .key       (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
         );
      end else if (i == CAPACITY - 1) begin : g_tail
         assign boundary[i] = !cell_lt[i] && cell_lt[i-1];
         sset_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (cell_new),
            .left_key  (cell_key[i-1]),
            .right_key (cell_key[i]),
            .left_lt   (cell_lt[i-1]),
            .key       (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
         );
      end else begin : g_mid
         assign boundary[i] = !cell_lt[i] && cell_lt[i-1];
         sset_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (cell_occ[i]),
            .new_key   (cell_new),
            .left_key  (cell_key[i-1]),
            .right_key (cell_key[i+1]),
            .left_lt   (cell_lt[i-1]),
            .key       (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
         );
      end
   end

   assign found = |cell_eq;
   assign full  = (count_ff == CW'(CAPACITY));

   // Position of the first key not below the request key
   always_comb begin
      rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rank = rank | ({sset_pkg::RANK_W{boundary[i]}} & sset_pkg::RANK_W'(i));
      end
   end

   always_comb begin
      status = sset_pkg::STAT_MISS;
      do_ins = 1'b0;
      do_del = 1'b0;
      if (!range_ok_ff) begin
         status = sset_pkg::STAT_RANGE;
      end else begin
         unique case (op_ff)
            sset_pkg::REQ_INSERT: begin
               priority if (found) begin
                  status = sset_pkg::STAT_MISS;
               end else if (full) begin
                  status = sset_pkg::STAT_FULL;
               end else begin
                  status = sset_pkg::STAT_DONE;
                  do_ins = 1'b1;
               end
            end
            sset_pkg::REQ_DELETE: begin
               if (found) begin
                  status = sset_pkg::STAT_DONE;
                  do_del = 1'b1;
               end
            end
            default: begin
               if (found) begin
                  status = sset_pkg::STAT_DONE;
               end
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_UPDATE;
         S_UPDATE: if (commit) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Hold the result beat while stalled; load a new one on commit
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_in = rsp_ff;
      if (commit) begin
         rsp_in.status      = status;
         rsp_in.rank        = (status == sset_pkg::STAT_DONE) ? rank : '0;
         rsp_in.entry_count = sset_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff       <= req_data.req_type;
         range_ok_ff <= range_ok;
         val_ff      <= val_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/sset_checker.sv]
// Port-level checks for the sorted set core, bound to the top level.
module sset_checker #(
   parameter int unsigned CAPACITY = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sset_pkg::rsp_type rsp_data
);

   // A stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // One request in flight: the beat after an accepted request is stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // Only a completed request reports a rank
   a_rank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != sset_pkg::STAT_DONE) |-> rsp_data.rank == '0)
      else $error("nonzero rank on a request that did not complete");

   // Count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 127) || (32'(rsp_data.entry_count) <= CAPACITY))
      else $error("entry count above capacity");

   // A full store is only reported with the count at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == sset_pkg::STAT_FULL) |->
         (CAPACITY > 127) || (32'(rsp_data.entry_count) == CAPACITY))
      else $error("store full reported below capacity");

endmodule

bind sorted_set_search_insert_delete_core sset_checker #(.CAPACITY(CAPACITY)) u_sset_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
